[hw/rtl/tctw_pkg.sv]
// Package for the text cell terminal writer: command codes, register indexes,
// character constants, state and fill-kind types, saturating increment.
// No dependencies.
package tctw_pkg;

    localparam int CHAR_W = 8;
    localparam int ATTR_W = 58;
    localparam int CELL_W = CHAR_W + ATTR_W;

    localparam logic [7:0] CH_CR    = 8'd13;
    localparam logic [7:0] CH_LF    = 8'd10;
    localparam logic [7:0] CH_SPACE = 8'd32;

    typedef enum logic [1:0] {
        CMD_PUT   = 2'd0,
        CMD_SET   = 2'd1,
        CMD_CLEAR = 2'd2,
        CMD_READ  = 2'd3
    } t_cmd;

    typedef enum logic [2:0] {
        REG_COLS  = 3'd0,
        REG_ROWS  = 3'd1,
        REG_WRAP  = 3'd2,
        REG_AUTO  = 3'd3,
        REG_ATTR  = 3'd4
    } t_reg_idx;

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_EXEC   = 4'b0010,
        S_RDWAIT = 4'b0100,
        S_FILL   = 4'b1000
    } t_state;

    typedef enum logic [1:0] {
        FK_INIT   = 2'd0,
        FK_CLEAR  = 2'd1,
        FK_SCROLL = 2'd2
    } t_fill_kind;

    function automatic logic [7:0] f_sat_inc(input logic [7:0] v);
        return (v == 8'hFF) ? v : v + 8'd1;
    endfunction

endpackage

[hw/rtl/text_cell_terminal_writer.sv]
// Text cell terminal writer: character grid with cursor, scroll ring and clear.
// Depends on tctw_pkg and tctw_ram.
//
// Usage:
//   Command items arrive on s_axis (tuser = command, tdata = char, x, y). Each
//   item gives exactly one result item on m_axis: the read cell (character,
//   attribute, in-range flag) and the cursor after the command.
//   Registers are written through the APB port (64-bit data, register i at 8*i).
// Work steps:
//   Put character, set cursor and a read outside the grid: accept, then one
//   work step; a read inside the grid adds a wait for the registered RAM read.
//   A line feed that scrolls adds a sweep over the grid columns of one row;
//   clear adds a sweep over every cell of the whole store (MAX_COLS * MAX_ROWS).
//   The result passes through the pending register into the output register.
//   After a write of the row count the first item first brings the ring offset
//   below the height by repeated subtraction. No new item is taken while one
//   is at work. The store has a single RAM port pair (one write, one read per cycle).
// Reset:
//   A clearing pass writes spaces with attribute zero into all MAX_COLS *
//   MAX_ROWS cells (8192 by default); no item is taken meanwhile,
//   configuration writes are taken as ever.
// Stall:
//   A waiting result is held in the output register; one more item is still
//   accepted and worked, and holds in a pending register until the output
//   register frees up. The input stalls while that pending result waits.
module text_cell_terminal_writer #(
    parameter int MAX_COLS = 128,
    parameter int MAX_ROWS = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // stream in
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // char_code[7:0], pos_x[15:8], pos_y[23:16]
    input  logic [1:0]  s_axis_tuser,   // command[1:0]
    // stream out
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [87:0] m_axis_tdata,   // cell_char[7:0], cell_attr[65:8],
                                        // cursor_col[73:66], cursor_row[81:74], zero[87:82]
    output logic [0:0]  m_axis_tuser,   // in_range[0]
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [5:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready
);

    localparam int DEPTH = MAX_COLS * MAX_ROWS;
    localparam int AW    = $clog2(DEPTH);
    localparam int TW    = $clog2(MAX_ROWS);
    localparam int CNTW  = $clog2(DEPTH + 1);
    localparam int CW    = tctw_pkg::CELL_W;
    localparam int ATW   = tctw_pkg::ATTR_W;

    // configuration registers
    logic [7:0]     r_cols, n_cols;
    logic [6:0]     r_rows, n_rows;
    logic           r_wrap, n_wrap;
    logic           r_auto, n_auto;
    logic [ATW-1:0] r_attr, n_attr;

    // control state
    tctw_pkg::t_state     r_state, n_state;
    tctw_pkg::t_fill_kind r_fill_kind, n_fill_kind;
    logic                 r_fill_zero, n_fill_zero;
    logic [AW-1:0]        r_fill_addr, n_fill_addr;
    logic [CNTW-1:0]      r_fill_cnt, n_fill_cnt;
    logic [TW-1:0]        r_top, n_top;         // ring offset as written
    logic [TW-1:0]        r_top_mod, n_top_mod; // ring offset mod current height
    logic                 r_mod_ok, n_mod_ok;
    logic [7:0]           r_ccol, n_ccol;
    logic [7:0]           r_crow, n_crow;
    logic                 r_pend, n_pend;
    logic                 r_out_valid, n_out_valid;

    // payload
    tctw_pkg::t_cmd r_cmd, n_cmd;
    logic [7:0]     r_char, n_char;
    logic [7:0]     r_px, n_px;
    logic [7:0]     r_py, n_py;
    logic [7:0]     r_res_char, n_res_char;
    logic [ATW-1:0] r_res_attr, n_res_attr;
    logic           r_res_inr, n_res_inr;
    logic [87:0]    r_out_data, n_out_data;
    logic           r_out_user, n_out_user;

    // RAM access
    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    logic [CW-1:0] ram_wdata;
    logic          ram_re;
    logic [AW-1:0] ram_raddr;
    logic [CW-1:0] ram_rdata;

    // geometry and addressing
    logic [8:0]    g_cols;
    logic [7:0]    g_rows;
    logic [7:0]    sel_col;
    logic [7:0]    sel_row;
    logic          sel_in;
    logic [8:0]    row_sum;
    logic [TW-1:0] phys_row;
    logic [AW-1:0] cell_addr;
    logic [AW-1:0] scroll_base;
    logic [7:0]    lf_row;
    logic [7:0]    adv_col;
    logic [7:0]    top_inc;
    logic          out_free;
    logic          in_acc;
    logic          cfg_wr;

    // clamp the geometry to the store
    assign g_cols = (r_cols == 8'd0) ? 9'd1 :
                    ({1'b0, r_cols} > 9'(MAX_COLS)) ? 9'(MAX_COLS) : {1'b0, r_cols};
    assign g_rows = (r_rows == 7'd0) ? 8'd1 :
                    ({1'b0, r_rows} > 8'(MAX_ROWS)) ? 8'(MAX_ROWS) : {1'b0, r_rows};

    // read uses the given position, print uses the cursor
    assign sel_col = (r_cmd == tctw_pkg::CMD_READ) ? r_px : r_ccol;
    assign sel_row = (r_cmd == tctw_pkg::CMD_READ) ? r_py : r_crow;
    assign sel_in  = ({1'b0, sel_col} < g_cols) && (sel_row < g_rows);

    // both ring offset and row stay below the height, so one subtract wraps the sum
    assign row_sum     = {1'b0, sel_row} + 9'(r_top_mod);
    assign phys_row    = (row_sum >= {1'b0, g_rows}) ? TW'(row_sum - {1'b0, g_rows})
                                                     : TW'(row_sum);
    assign cell_addr   = AW'(phys_row) * AW'(MAX_COLS) + AW'(sel_col);
    assign scroll_base = AW'(r_top_mod) * AW'(MAX_COLS);

    assign lf_row  = tctw_pkg::f_sat_inc(r_crow);
    assign adv_col = tctw_pkg::f_sat_inc(r_ccol);
    assign top_inc = 8'(r_top_mod) + 8'd1;

    assign out_free      = !r_out_valid || m_axis_tready;
    assign s_axis_tready = (r_state == tctw_pkg::S_IDLE) && (!r_pend || out_free);
    assign in_acc        = s_axis_tvalid && s_axis_tready;
    assign cfg_wr        = psel && penable && pwrite;

    always_comb begin
        n_state     = r_state;
        n_fill_kind = r_fill_kind;
        n_fill_zero = r_fill_zero;
        n_fill_addr = r_fill_addr;
        n_fill_cnt  = r_fill_cnt;
        n_top       = r_top;
        n_top_mod   = r_top_mod;
        n_mod_ok    = r_mod_ok;
        n_ccol      = r_ccol;
        n_crow      = r_crow;
        n_pend      = r_pend;
        n_out_valid = r_out_valid;
        n_cmd       = r_cmd;
        n_char      = r_char;
        n_px        = r_px;
        n_py        = r_py;
        n_res_char  = r_res_char;
        n_res_attr  = r_res_attr;
        n_res_inr   = r_res_inr;
        n_out_data  = r_out_data;
        n_out_user  = r_out_user;
        n_cols      = r_cols;
        n_rows      = r_rows;
        n_wrap      = r_wrap;
        n_auto      = r_auto;
        n_attr      = r_attr;
        ram_we      = 1'b0;
        ram_waddr   = cell_addr;
        ram_wdata   = {r_attr, r_char};
        ram_re      = 1'b0;
        ram_raddr   = cell_addr;

        // drain the pending result into the output register
        if (r_pend && out_free) begin
            n_pend      = 1'b0;
            n_out_valid = 1'b1;
            n_out_data  = {6'd0, r_crow, r_ccol, r_res_attr, r_res_char};
            n_out_user  = r_res_inr;
        end else if (m_axis_tready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            tctw_pkg::S_IDLE: begin
                if (in_acc) begin
                    n_cmd   = tctw_pkg::t_cmd'(s_axis_tuser);
                    n_char  = s_axis_tdata[7:0];
                    n_px    = s_axis_tdata[15:8];
                    n_py    = s_axis_tdata[23:16];
                    n_state = tctw_pkg::S_EXEC;
                end
            end
            tctw_pkg::S_EXEC: begin
                n_res_char = 8'd0;
                n_res_attr = '0;
                n_res_inr  = 1'b0;
                if (!r_mod_ok) begin
                    // reduce the ring offset after a height change
                    if (8'(r_top_mod) >= g_rows) begin
                        n_top_mod = TW'(8'(r_top_mod) - g_rows);
                    end else begin
                        n_mod_ok = 1'b1;
                    end
                end else begin
                    n_state = tctw_pkg::S_IDLE;
                    n_pend  = 1'b1;
                    case (r_cmd)
                        tctw_pkg::CMD_PUT: begin
                            if (r_char == tctw_pkg::CH_CR) begin
                                n_ccol = 8'd0;
                            end else if (r_char == tctw_pkg::CH_LF) begin
                                n_ccol = 8'd0;
                                n_crow = lf_row;
                                if (r_auto && (lf_row >= g_rows)) begin
                                    n_pend      = 1'b0;
                                    n_state     = tctw_pkg::S_FILL;
                                    n_fill_kind = tctw_pkg::FK_SCROLL;
                                    n_fill_zero = 1'b0;
                                    n_fill_addr = scroll_base;
                                    n_fill_cnt  = CNTW'(g_cols);
                                end
                            end else begin
                                ram_we = sel_in;
                                if (r_wrap && ({1'b0, adv_col} >= g_cols)) begin
                                    n_ccol = 8'd0;
                                    n_crow = lf_row;
                                end else begin
                                    n_ccol = adv_col;
                                end
                            end
                        end
                        tctw_pkg::CMD_SET: begin
                            n_ccol = r_px;
                            n_crow = r_py;
                        end
                        tctw_pkg::CMD_CLEAR: begin
                            n_pend      = 1'b0;
                            n_state     = tctw_pkg::S_FILL;
                            n_fill_kind = tctw_pkg::FK_CLEAR;
                            n_fill_zero = 1'b0;
                            n_fill_addr = '0;
                            n_fill_cnt  = CNTW'(DEPTH);
                        end
                        tctw_pkg::CMD_READ: begin
                            if (sel_in) begin
                                ram_re  = 1'b1;
                                n_pend  = 1'b0;
                                n_state = tctw_pkg::S_RDWAIT;
                            end
                        end
                        default: begin
                            n_state = tctw_pkg::S_IDLE;
                        end
                    endcase
                end
            end
            tctw_pkg::S_RDWAIT: begin
                n_res_char = ram_rdata[7:0];
                n_res_attr = ram_rdata[CW-1:8];
                n_res_inr  = 1'b1;
                n_pend     = 1'b1;
                n_state    = tctw_pkg::S_IDLE;
            end
            tctw_pkg::S_FILL: begin
                ram_we      = 1'b1;
                ram_waddr   = r_fill_addr;
                ram_wdata   = {(r_fill_zero ? {ATW{1'b0}} : r_attr), tctw_pkg::CH_SPACE};
                n_fill_addr = r_fill_addr + AW'(1);
                n_fill_cnt  = r_fill_cnt - CNTW'(1);
                if (r_fill_cnt == CNTW'(1)) begin
                    n_state = tctw_pkg::S_IDLE;
                    case (r_fill_kind)
                        tctw_pkg::FK_CLEAR: begin
                            n_top     = '0;
                            n_top_mod = '0;
                            n_mod_ok  = 1'b1;
                            n_pend    = 1'b1;
                        end
                        tctw_pkg::FK_SCROLL: begin
                            // old top row is now the blank bottom row
                            n_top     = (top_inc >= g_rows) ? '0 : TW'(top_inc);
                            n_top_mod = (top_inc >= g_rows) ? '0 : TW'(top_inc);
                            if (r_crow != 8'd0) begin
                                n_crow = r_crow - 8'd1;
                            end
                            n_pend = 1'b1;
                        end
                        default: begin
                            n_pend = 1'b0;
                        end
                    endcase
                end
            end
            default: begin
                n_state = tctw_pkg::S_IDLE;
            end
        endcase

        // configuration write
        if (cfg_wr) begin
            case (tctw_pkg::t_reg_idx'(paddr[5:3]))
                tctw_pkg::REG_COLS: n_cols = pwdata[7:0];
                tctw_pkg::REG_ROWS: begin
                    n_rows    = pwdata[6:0];
                    n_top_mod = r_top;
                    n_mod_ok  = 1'b0;
                end
                tctw_pkg::REG_WRAP: n_wrap = pwdata[0];
                tctw_pkg::REG_AUTO: n_auto = pwdata[0];
                tctw_pkg::REG_ATTR: n_attr = pwdata[ATW-1:0];
                default: begin
                    n_cols = r_cols;
                end
            endcase
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= tctw_pkg::S_FILL;
            r_fill_kind <= tctw_pkg::FK_INIT;
            r_fill_zero <= 1'b1;
            r_fill_addr <= '0;
            r_fill_cnt  <= CNTW'(DEPTH);
            r_top       <= '0;
            r_top_mod   <= '0;
            r_mod_ok    <= 1'b1;
            r_ccol      <= 8'd0;
            r_crow      <= 8'd0;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
            r_cols      <= 8'd80;
            r_rows      <= 7'd25;
            r_wrap      <= 1'b0;
            r_auto      <= 1'b0;
            r_attr      <= '0;
        end else begin
            r_state     <= n_state;
            r_fill_kind <= n_fill_kind;
            r_fill_zero <= n_fill_zero;
            r_fill_addr <= n_fill_addr;
            r_fill_cnt  <= n_fill_cnt;
            r_top       <= n_top;
            r_top_mod   <= n_top_mod;
            r_mod_ok    <= n_mod_ok;
            r_ccol      <= n_ccol;
            r_crow      <= n_crow;
            r_pend      <= n_pend;
            r_out_valid <= n_out_valid;
            r_cols      <= n_cols;
            r_rows      <= n_rows;
            r_wrap      <= n_wrap;
            r_auto      <= n_auto;
            r_attr      <= n_attr;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_cmd      <= n_cmd;
        r_char     <= n_char;
        r_px       <= n_px;
        r_py       <= n_py;
        r_res_char <= n_res_char;
        r_res_attr <= n_res_attr;
        r_res_inr  <= n_res_inr;
        r_out_data <= n_out_data;
        r_out_user <= n_out_user;
    end

    tctw_ram #(
        .WIDTH (CW),
        .DEPTH (DEPTH)
    ) u_cells (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tuser  = r_out_user;
    assign pready        = 1'b1;

    always_comb begin
        case (tctw_pkg::t_reg_idx'(paddr[5:3]))
            tctw_pkg::REG_COLS: prdata = {56'd0, r_cols};
            tctw_pkg::REG_ROWS: prdata = {57'd0, r_rows};
            tctw_pkg::REG_WRAP: prdata = {63'd0, r_wrap};
            tctw_pkg::REG_AUTO: prdata = {63'd0, r_auto};
            tctw_pkg::REG_ATTR: prdata = {6'd0, r_attr};
            default:            prdata = 64'd0;
        endcase
    end

    // an accepted item always goes to work in the next cycle
    a_accept_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> (r_state == tctw_pkg::S_EXEC))
        else $error("accepted item did not enter execution");

    // a sweep never runs past its count
    a_fill_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == tctw_pkg::S_FILL) |-> (r_fill_cnt != '0))
        else $error("fill sweep count underflow");

    // the store is written only while an item works or a sweep runs
    a_write_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_we |-> ((r_state == tctw_pkg::S_EXEC) || (r_state == tctw_pkg::S_FILL)))
        else $error("cell store written outside execution or sweep");

    // a pending result only waits between items
    a_pend_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend |-> (r_state == tctw_pkg::S_IDLE))
        else $error("pending result while an item is at work");

endmodule

[hw/rtl/tctw_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module tctw_ram #(
    parameter int WIDTH = 66,
    parameter int DEPTH = 8192
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule
